[sv/rlfb_pkg.sv]
// Shared types, codes and helper functions for the LED fade and blink engine.
`default_nettype none

package rlfb_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int DEF_CHANNELS = 3;

  localparam logic [7:0] FULL_ON  = 8'hFE;
  localparam logic [7:0] FULL_OFF = 8'h00;

  // command codes
  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  // fade direction codes
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b10;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] target_red;
    logic [7:0] target_green;
    logic [7:0] target_blue;
    logic [7:0] fade_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       fading;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic prep;
    logic mul;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic start_req;
  } ctl_sts_t;

  // floor(256 / m) for m in 0..255, 0 for m == 0; compare chain against constants
  function automatic logic [8:0] recip256(input logic [7:0] m);
    logic [8:0] q;
    if      (m > 8'd128) q = 9'd1;
    else if (m > 8'd85)  q = 9'd2;
    else if (m > 8'd64)  q = 9'd3;
    else if (m > 8'd51)  q = 9'd4;
    else if (m > 8'd42)  q = 9'd5;
    else if (m > 8'd36)  q = 9'd6;
    else if (m > 8'd32)  q = 9'd7;
    else if (m > 8'd28)  q = 9'd8;
    else if (m > 8'd25)  q = 9'd9;
    else if (m > 8'd23)  q = 9'd10;
    else if (m > 8'd21)  q = 9'd11;
    else if (m > 8'd19)  q = 9'd12;
    else if (m > 8'd18)  q = 9'd13;
    else if (m > 8'd17)  q = 9'd14;
    else if (m > 8'd16)  q = 9'd15;
    else begin
      case (m)
        8'd16:   q = 9'd16;
        8'd15:   q = 9'd17;
        8'd14:   q = 9'd18;
        8'd13:   q = 9'd19;
        8'd12:   q = 9'd21;
        8'd11:   q = 9'd23;
        8'd10:   q = 9'd25;
        8'd9:    q = 9'd28;
        8'd8:    q = 9'd32;
        8'd7:    q = 9'd36;
        8'd6:    q = 9'd42;
        8'd5:    q = 9'd51;
        8'd4:    q = 9'd64;
        8'd3:    q = 9'd85;
        8'd2:    q = 9'd128;
        8'd1:    q = 9'd256;
        default: q = 9'd0;
      endcase
    end
    return q;
  endfunction

  // target taken by a channel from a set-target item
  function automatic logic [7:0] item_target(input in_item_t item, input int idx);
    logic [7:0] t;
    case (idx)
      0:       t = item.target_red;
      1:       t = item.target_green;
      2:       t = item.target_blue;
      default: t = FULL_OFF;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[sv/rlfb_ctrl.sv]
// Controller state machine: sequences accept, execute, fade setup and result load.
`default_nettype none

module rlfb_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  rlfb_pkg::ctl_sts_t  sts,
  output rlfb_pkg::ctl_cmd_t  cmd
);
  import rlfb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_PREP = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.start_req ? ST_PREP : ST_DONE;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the previous result to be transferred
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[sv/rlfb_datapath.sv]
// Datapath: channel levels, targets, directions, step delays, blink state and result register.
`default_nettype none

module rlfb_datapath #(
  parameter int CHANNELS = rlfb_pkg::DEF_CHANNELS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rlfb_pkg::in_item_t  in_data,
  input  wire                 cfg_we,
  input  wire [7:0]           cfg_wdata,
  input  rlfb_pkg::ctl_cmd_t  cmd,
  output rlfb_pkg::ctl_sts_t  sts,
  output rlfb_pkg::out_item_t out_data
);
  import rlfb_pkg::*;

  in_item_t   item_r;
  logic [7:0] period_r;

  logic [7:0]  level_r [CHANNELS];
  logic [7:0]  level_nxt [CHANNELS];
  logic [7:0]  target_r [CHANNELS];
  logic [7:0]  target_nxt [CHANNELS];
  logic [1:0]  dir_r [CHANNELS];
  logic [1:0]  dir_nxt [CHANNELS];
  logic [15:0] delay_r [CHANNELS];
  logic [15:0] delay_nxt [CHANNELS];
  logic [15:0] cnt_r [CHANNELS];
  logic [15:0] cnt_nxt [CHANNELS];
  logic [8:0]  quo_r [CHANNELS];
  logic [8:0]  quo_nxt [CHANNELS];

  logic [7:0] ftime_r, ftime_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic       phase_r, phase_nxt;

  logic       phase_hit;
  logic [7:0] lvl_pad [MAX_CHANNELS];
  logic       any_moving;
  out_item_t  out_r, out_nxt;

  assign phase_hit     = (period_r != 8'd0) && (tick_r == period_r);
  assign sts.start_req = (item_r.command == CMD_SET) ||
                         ((item_r.command == CMD_TICK) && phase_hit);

  always_comb begin
    level_nxt  = level_r;
    target_nxt = target_r;
    dir_nxt    = dir_r;
    delay_nxt  = delay_r;
    cnt_nxt    = cnt_r;
    quo_nxt    = quo_r;
    ftime_nxt  = ftime_r;
    tick_nxt   = tick_r;
    phase_nxt  = phase_r;

    if (cmd.exec) begin
      case (item_r.command)
        CMD_STEP: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (dir_r[c] != DIR_NONE && level_r[c] != target_r[c]) begin
              cnt_nxt[c] = cnt_r[c] + 16'd1;
              if (cnt_r[c] >= delay_r[c]) begin
                cnt_nxt[c]   = '0;
                level_nxt[c] = (dir_r[c] == DIR_UP) ? level_r[c] + 8'd1
                                                    : level_r[c] - 8'd1;
                if (level_nxt[c] == target_r[c]) dir_nxt[c] = DIR_NONE;
              end
            end
          end
        end
        CMD_TICK: begin
          if (phase_hit) begin
            phase_nxt = ~phase_r;
            // phase 1 goes back to white, phase 0 goes to red
            for (int c = 0; c < CHANNELS; c++)
              target_nxt[c] = (phase_r || c == 0) ? FULL_ON : FULL_OFF;
            tick_nxt = 8'd1;
          end else if (period_r != 8'd0) begin
            tick_nxt = tick_r + 8'd1;
          end
        end
        CMD_SET: begin
          for (int c = 0; c < CHANNELS; c++)
            target_nxt[c] = item_target(item_r, c);
          ftime_nxt = item_r.fade_time;
        end
        default: ;
      endcase
    end

    if (cmd.prep) begin
      for (int c = 0; c < CHANNELS; c++) begin
        dir_nxt[c] = DIR_NONE;
        if (ftime_r == 8'd0) begin
          level_nxt[c] = target_r[c];
        end else if (target_r[c] > level_r[c]) begin
          dir_nxt[c] = DIR_UP;
          quo_nxt[c] = recip256(target_r[c] - level_r[c]);
        end else if (target_r[c] < level_r[c]) begin
          dir_nxt[c] = DIR_DOWN;
          quo_nxt[c] = recip256(level_r[c] - target_r[c]);
        end else begin
          quo_nxt[c] = 9'd0;
        end
      end
    end

    // a jump leaves the step delays as they were
    if (cmd.mul && ftime_r != 8'd0) begin
      for (int c = 0; c < CHANNELS; c++)
        delay_nxt[c] = {7'd0, quo_r[c]} * {8'd0, ftime_r};
    end
  end

  always_comb begin
    for (int c = 0; c < MAX_CHANNELS; c++) lvl_pad[c] = 8'd0;
    for (int c = 0; c < CHANNELS; c++)     lvl_pad[c] = level_r[c];
    any_moving = 1'b0;
    for (int c = 0; c < CHANNELS; c++)
      if (dir_r[c] != DIR_NONE) any_moving = 1'b1;
    out_nxt.red_level   = lvl_pad[0];
    out_nxt.green_level = lvl_pad[1];
    out_nxt.blue_level  = lvl_pad[2];
    out_nxt.fading      = any_moving;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 8'd0;
      ftime_r  <= 8'd0;
      tick_r   <= 8'd0;
      phase_r  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        level_r[c]  <= 8'd0;
        target_r[c] <= 8'd0;
        dir_r[c]    <= DIR_NONE;
        delay_r[c]  <= 16'd0;
        cnt_r[c]    <= 16'd0;
      end
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      ftime_r  <= ftime_nxt;
      tick_r   <= tick_nxt;
      phase_r  <= phase_nxt;
      level_r  <= level_nxt;
      target_r <= target_nxt;
      dir_r    <= dir_nxt;
      delay_r  <= delay_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load)     item_r <= in_data;
    if (cmd.out_load) out_r  <= out_nxt;
    quo_r <= quo_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

[sv/rgb_led_fade_blink_engine_unit.sv]
// Top level of the RGB LED fade and blink engine.
//
// Input channel in_valid/in_ready/in_data carries one command: fade step,
// slow tick or set target. Every accepted item yields one result on
// out_valid/out_ready/out_data: the channel levels and a fading flag.
// cfg_we/cfg_wdata write the blink period (slow ticks per blink phase,
// zero turns blinking off); write it only while the engine is idle.
// A fade step, a slow tick without phase change or an unused command is
// executed and its result loaded; a set target or a blink phase change
// adds the step-delay setup in between (reciprocal lookup, then the delay
// multiply). One item is in work at a time, so the next transfer is taken
// only once the previous result is loaded into the output register.
// The result sits in an output register; while the receiver stalls, a new
// item is still taken and worked, and waits for that register to free up.
// Synchronous reset clears all levels, targets, fades, blink state, the
// blink period and the output valid.
`default_nettype none

module rgb_led_fade_blink_engine_unit #(
  parameter int CHANNELS = rlfb_pkg::DEF_CHANNELS
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  rlfb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output rlfb_pkg::out_item_t out_data,
  input  wire                 cfg_we,
  input  wire [7:0]           cfg_wdata
);
  import rlfb_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rlfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlfb_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[sv/rlfb_checker.sv]
// Port-level checker for the LED fade and blink engine, bound to the top level.
`default_nettype none

module rlfb_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_ready,
  input rlfb_pkg::in_item_t  in_data,
  input wire                 out_valid,
  input wire                 out_ready,
  input rlfb_pkg::out_item_t out_data
);

  // one item in work at a time: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  // a result never shows straight after its transfer: execute and result load come between
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result shown in the cycle after a transfer");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

  // a waiting input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input dropped or changed");

endmodule

bind rgb_led_fade_blink_engine_unit rlfb_checker u_rlfb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
